[sv/phd_pkg.sv]
// Package for the pinned-head deque: field widths, operation and status codes,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package phd_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_FRONT = 2'd0,
        FUNC_INS_BACK  = 2'd1,
        FUNC_REM_FRONT = 2'd2,
        FUNC_REM_BACK  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_HEAD_ONLY = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic grow;     // one more element beside the head
        logic shrink;   // one element fewer beside the head
        logic head_on;  // head present once this cycle's item is done
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic tail_zero;  // no element beside the head
        logic tail_full;  // head plus ring fill the capacity
    } t_dp_stat;

endpackage

[sv/pinned_head_deque.sv]
// Top level of the pinned-head deque: controller plus occupancy datapath.
// Depends on phd_pkg, phd_ctrl and phd_datapath.
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+-------------------------
//  input   | i_valid / o_ready              | in        | i_func[1:0], i_value[31:0]
//  result  | o_valid / i_ready              | out       | o_count[8:0], o_status[1:0]
//
// One item per cycle while o_ready is high: every operation touches only the
// list state and the occupancy counter, and the result shows in the output
// register on the next cycle. A waiting result does not block the next item once
// i_ready is high; o_ready drops only while a result is held and i_ready is low.
// Reset is synchronous and active low; it empties the list and drops any
// held result.
//
// Stored values are never read back by any operation (removals discard them
// and results carry only count and status), so the block keeps the list's
// occupancy only; i_value has no effect on any result.
module pinned_head_deque #(
    parameter int CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [phd_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [phd_pkg::VALUE_W-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [phd_pkg::COUNT_W-1:0]   o_count,
    output logic [phd_pkg::STATUS_W-1:0]  o_status
);
    import phd_pkg::*;

    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic [COUNT_W-1:0]  total_next;

    // Decode, hold list state and the result register
    phd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_count      (o_count),
        .o_status     (o_status),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat),
        .i_total_next (total_next)
    );

    // Advance or retreat the occupancy beside the head
    phd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_total_next (total_next)
    );

endmodule

[sv/phd_datapath.sv]
// Occupancy datapath of the pinned-head deque: the count of elements beside
// the head and the element total after each item. Depends on phd_pkg.
module phd_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  phd_pkg::t_dp_cmd        i_cmd,
    output phd_pkg::t_dp_stat       o_stat,
    output logic [phd_pkg::COUNT_W-1:0] o_total_next
);
    import phd_pkg::*;

    localparam int TAIL_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam logic [TAIL_W-1:0] TAIL_MAX = TAIL_W'(CAPACITY - 1);

    logic [TAIL_W-1:0] r_tail;
    logic [TAIL_W-1:0] n_tail;
    logic [TAIL_W:0]   total;

    always_comb begin
        n_tail = r_tail;
        if (i_cmd.grow) begin
            n_tail = r_tail + TAIL_W'(1);
        end else if (i_cmd.shrink) begin
            n_tail = r_tail - TAIL_W'(1);
        end
    end

    // Total includes the head; masked to the result width.
    assign total        = i_cmd.head_on ? ({1'b0, n_tail} + (TAIL_W+1)'(1)) : '0;
    assign o_total_next = COUNT_W'(total);

    assign o_stat.tail_zero = (r_tail == '0);
    assign o_stat.tail_full = (r_tail == TAIL_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
        end else begin
            r_tail <= n_tail;
        end
    end

endmodule

[sv/phd_ctrl.sv]
// Controller of the pinned-head deque: list state machine, operation decode
// and the registered result stage. Depends on phd_pkg.
module phd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [phd_pkg::FUNC_W-1:0]    i_func,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [phd_pkg::COUNT_W-1:0]   o_count,
    output logic [phd_pkg::STATUS_W-1:0]  o_status,
    output phd_pkg::t_dp_cmd              o_cmd,
    input  phd_pkg::t_dp_stat             i_stat,
    input  logic [phd_pkg::COUNT_W-1:0]   i_total_next
);
    import phd_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_HEADED
    } t_state;

    t_state               r_state, n_state;
    logic                 r_valid;
    logic [COUNT_W-1:0]   r_count;
    t_status              r_status, n_status;
    logic                 accept;
    logic                 is_insert;

    assign o_ready   = !r_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_insert = (t_func'(i_func) == FUNC_INS_FRONT) ||
                       (t_func'(i_func) == FUNC_INS_BACK);

    always_comb begin
        n_state       = r_state;
        n_status      = STATUS_DONE;
        o_cmd.grow    = 1'b0;
        o_cmd.shrink  = 1'b0;
        if (accept) begin
            unique case (t_func'(i_func))
                FUNC_INS_FRONT, FUNC_INS_BACK: begin
                    if (r_state == ST_EMPTY) begin
                        n_state = ST_HEADED;
                    end else if (i_stat.tail_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        o_cmd.grow = 1'b1;
                    end
                end
                FUNC_REM_FRONT, FUNC_REM_BACK: begin
                    if (r_state == ST_EMPTY) begin
                        n_status = STATUS_EMPTY;
                    end else if (i_stat.tail_zero) begin
                        n_status = STATUS_HEAD_ONLY;
                    end else begin
                        o_cmd.shrink = 1'b1;
                    end
                end
                default: begin
                    n_status = STATUS_DONE;
                end
            endcase
        end
        o_cmd.head_on = (r_state == ST_HEADED) || (accept && is_insert);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_EMPTY;
            r_valid  <= 1'b0;
            r_status <= STATUS_DONE;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_valid  <= 1'b1;
                r_count  <= i_total_next;
                r_status <= n_status;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_count  = r_count;
    assign o_status = r_status;

endmodule

[sv/phd_checker.sv]
// Port-level checks for the pinned-head deque, bound to the top level.
// Depends on phd_pkg and pinned_head_deque.
module phd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [phd_pkg::COUNT_W-1:0]   o_count,
    input  logic [phd_pkg::STATUS_W-1:0]  o_status
);
    import phd_pkg::*;

    // Drop any held result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_count) && $stable(o_status))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_head_only_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_HEAD_ONLY) |-> (o_count == COUNT_W'(1)))
        else $error("head-only status with count other than one");

endmodule

bind pinned_head_deque phd_checker u_phd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_count  (o_count),
    .o_status (o_status)
);
